@@ design/ring_log_offset_lookup_core_macros.svh @@
// ----------------------------------------------------------------------------
// ring_log_offset_lookup_core_macros
// assertion macros shared by the ring log lookup design
// ----------------------------------------------------------------------------
`ifndef RING_LOG_OFFSET_LOOKUP_CORE_MACROS_SVH
`define RING_LOG_OFFSET_LOOKUP_CORE_MACROS_SVH

// antecedent in this cycle implies consequent in the next
`define RLOL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// condition must never hold
`define RLOL_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

@@ design/rlol_pkg.sv @@
// ----------------------------------------------------------------------------
// rlol_pkg
// types, constants and helpers for the ring log offset lookup
// ----------------------------------------------------------------------------
package rlol_pkg;

    localparam int DEPTH  = 10;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int HDL_W  = 32;
    localparam int SIZE_W = 16;
    localparam int OFF_W  = 20;
    localparam int ACC_W  = (SIZE_W + CNT_W > OFF_W) ? (SIZE_W + CNT_W) : OFF_W;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_FIND = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [ACC_W-1:0] acc_t;

    typedef struct packed {
        logic              cmd;
        logic [HDL_W-1:0]  entry_handle;
        logic [SIZE_W-1:0] entry_size;
        logic [OFF_W-1:0]  char_pos;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [HDL_W-1:0]  found_handle;
        logic [SIZE_W-1:0] byte_in_entry;
    } rsp_t;

    typedef struct packed {
        logic [HDL_W-1:0]  handle;
        logic [SIZE_W-1:0] size;
    } entry_t;

    // store access issued by the sequencer
    typedef struct packed {
        logic   wr_en;
        idx_t   wr_addr;
        entry_t wr_data;
        logic   rd_en;
        idx_t   rd_addr;
    } mem_req_t;

    function automatic idx_t next_idx(input idx_t i);
        next_idx = (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

endpackage

@@ design/rlol_store.sv @@
// ----------------------------------------------------------------------------
// rlol_store
// entry memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module rlol_store (
    input  logic              clk,
    input  rlol_pkg::mem_req_t mreq,
    output rlol_pkg::entry_t  rd_data
);
    import rlol_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mreq.wr_en)
        begin
            mem[mreq.wr_addr] <= mreq.wr_data;
        end
        if (mreq.rd_en)
        begin
            rd_data_reg <= mem[mreq.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/rlol_seq.sv @@
// ----------------------------------------------------------------------------
// rlol_seq
// ring index keeping and the size-accumulating walk for find
// ----------------------------------------------------------------------------
module rlol_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  rlol_pkg::req_t     req,
    output rlol_pkg::mem_req_t mreq,
    input  rlol_pkg::entry_t   rd_data,
    output logic               res_valid,
    output rlol_pkg::rsp_t     res,
    input  logic               res_load
);
    import rlol_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;
    idx_t   wr_idx_reg, wr_idx_next;
    idx_t   rd_idx_reg, rd_idx_next;
    logic   full_reg, full_next;
    idx_t   slot_reg, slot_next;
    cnt_t   k_reg, k_next;
    cnt_t   cnt_reg, cnt_next;
    acc_t   acc_reg, acc_next;
    logic [OFF_W-1:0] off_reg, off_next;
    rsp_t   res_reg, res_next;

    logic   accept;
    idx_t   wr_adv;
    idx_t   rd_adv;
    cnt_t   count;
    acc_t   sum;
    acc_t   off_ext;
    acc_t   diff;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;

    // entries between read and write index
    always_comb
    begin
        if (full_reg)
        begin
            count = CNT_W'(DEPTH);
        end
        else if (wr_idx_reg >= rd_idx_reg)
        begin
            count = CNT_W'(wr_idx_reg) - CNT_W'(rd_idx_reg);
        end
        else
        begin
            count = CNT_W'(wr_idx_reg) + CNT_W'(DEPTH) - CNT_W'(rd_idx_reg);
        end
    end

    assign wr_adv  = next_idx(wr_idx_reg);
    assign rd_adv  = full_reg ? wr_adv : rd_idx_reg;
    assign off_ext = ACC_W'(off_reg);
    assign sum     = acc_reg + ACC_W'(rd_data.size);
    assign diff    = off_ext - acc_reg;

    always_comb
    begin
        state_next  = state_reg;
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        full_next   = full_reg;
        slot_next   = slot_reg;
        k_next      = k_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        off_next    = off_reg;
        res_next    = res_reg;

        mreq.wr_en          = 1'b0;
        mreq.wr_addr        = wr_idx_reg;
        mreq.wr_data.handle = req.entry_handle;
        mreq.wr_data.size   = req.entry_size;
        mreq.rd_en          = 1'b0;
        mreq.rd_addr        = slot_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next = '0;
                    if (req.cmd == CMD_ADD)
                    begin
                        mreq.wr_en  = 1'b1;
                        wr_idx_next = wr_adv;
                        rd_idx_next = rd_adv;
                        if (wr_adv == rd_adv)
                        begin
                            full_next = 1'b1;
                        end
                        state_next = ST_RESP;
                    end
                    else if (count == '0)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        mreq.rd_en   = 1'b1;
                        mreq.rd_addr = rd_idx_reg;
                        slot_next    = next_idx(rd_idx_reg);
                        k_next       = '0;
                        cnt_next     = count;
                        acc_next     = '0;
                        off_next     = req.char_pos;
                        state_next   = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                if (off_ext < sum)
                begin
                    res_next.found         = 1'b1;
                    res_next.found_handle  = rd_data.handle;
                    res_next.byte_in_entry = diff[SIZE_W-1:0];
                    state_next             = ST_RESP;
                end
                else if (k_reg + 1'b1 == cnt_reg)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    // fetch the next entry while this one is checked
                    mreq.rd_en = 1'b1;
                    slot_next  = next_idx(slot_reg);
                    acc_next   = sum;
                    k_next     = k_reg + 1'b1;
                end
            end
            ST_RESP:
            begin
                if (res_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            full_reg   <= 1'b0;
            slot_reg   <= '0;
            k_reg      <= '0;
            cnt_reg    <= '0;
            acc_reg    <= '0;
            off_reg    <= '0;
            res_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            full_reg   <= full_next;
            slot_reg   <= slot_next;
            k_reg      <= k_next;
            cnt_reg    <= cnt_next;
            acc_reg    <= acc_next;
            off_reg    <= off_next;
            res_reg    <= res_next;
        end
    end

    assign res_valid = (state_reg == ST_RESP);
    assign res       = res_reg;

endmodule

@@ design/ring_log_offset_lookup_core.sv @@
// ----------------------------------------------------------------------------
// ring_log_offset_lookup_core
// ring log of handle/size entries with lookup of a character offset
// ----------------------------------------------------------------------------
// usage
//   req channel: one transaction per command; cmd add stores entry_handle and
//   entry_size, overwriting the oldest entry once the ring is full; cmd find
//   looks up char_pos in the concatenation of all stored entries, oldest first
//   rsp channel: exactly one transaction per command; found, found_handle and
//   byte_in_entry are all zero for add and for an offset past the stored data
// sequencing
//   add, or find on an empty ring: the response is formed without a walk
//   find: the walk reads one entry a cycle from the single read port of the
//   entry store and adds its size in the accumulator; the walk stops at the
//   first hit or after the last valid entry; the result then passes through
//   the output register, and the next command is taken once that is loaded
//   req_ready is low while a command is in progress
// stalls and reset
//   the result sits in an output register; while rsp_ready is low the next
//   result waits in the sequencer and no further command is taken
//   reset empties the ring (indices and full flag cleared); stored entries
//   are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
`include "ring_log_offset_lookup_core_macros.svh"

module ring_log_offset_lookup_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  rlol_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output rlol_pkg::rsp_t rsp
);
    import rlol_pkg::*;

    mem_req_t mreq;
    entry_t   rd_data;
    logic     res_valid;
    rsp_t     res;
    logic     res_load;

    logic     out_valid_reg, out_valid_next;
    rsp_t     out_reg, out_next;

    // a miss response that still carries a handle or offset
    logic     miss_payload;

    // entry store
    rlol_store u_store (
        .clk     (clk),
        .mreq    (mreq),
        .rd_data (rd_data)
    );

    // ring indices and the walk
    rlol_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .mreq      (mreq),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res       (res),
        .res_load  (res_load)
    );

    // output register loads when empty or being drained
    assign res_load = res_valid && (!out_valid_reg || rsp_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assign miss_payload = !rsp.found && (rsp.found_handle != '0 || rsp.byte_in_entry != '0);

    // one command in progress at a time
    `RLOL_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "command taken")
    // a finished result is held until the output register takes it
    `RLOL_ASSERT_NEXT(a_res_held, res_valid && !res_load, res_valid && $stable(res), "result lost")
    // a not-found result carries no handle or offset
    `RLOL_ASSERT_NEVER(a_miss_zero, rsp_valid && miss_payload, "miss with payload")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the ring log offset lookup core: add and find
// commands go in over the request channel and every response is compared
// field by field with an in-bench model of the ring
// ----------------------------------------------------------------------------
module testbench;

    import rlol_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 6;
    localparam int STALL_LIMIT   = 4000;   // cycles without any transaction
    localparam int DRAIN_CYCLES  = DEPTH + 8;
    localparam int REPORT_MAX    = 10;
    localparam int RANDOM_ITEMS  = 1000;

    // ------------------------------------------------------------------------
    // clock, reset and the block's ports
    // ------------------------------------------------------------------------
    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    always #CLK_HALF clk = ~clk;

    ring_log_offset_lookup_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // ------------------------------------------------------------------------
    // ring model: a copy of the log kept in step with accepted commands
    // ------------------------------------------------------------------------
    logic [HDL_W-1:0]  log_handle [DEPTH];
    logic [SIZE_W-1:0] log_size   [DEPTH];
    int unsigned       wr_slot   = 0;
    int unsigned       rd_slot   = 0;
    bit                log_full  = 1'b0;

    // responses still owed by the block, oldest first
    rsp_t lookup_results_q [$];

    // idle rates in percent, changed per traffic phase
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // run statistics
    int unsigned mismatch_count = 0;
    int unsigned adds_sent      = 0;
    int unsigned finds_sent     = 0;
    int unsigned finds_hit      = 0;
    int unsigned rsp_seen       = 0;
    int unsigned quiet_cycles   = 0;

    function automatic int unsigned stored_entries();
        if (log_full)
            return DEPTH;
        return (wr_slot + DEPTH - rd_slot) % DEPTH;
    endfunction

    // total number of characters held in the valid entries
    function automatic int unsigned stored_chars();
        int unsigned total;
        int unsigned slot;
        total = 0;
        slot  = rd_slot;
        for (int k = 0; k < stored_entries(); k++)
        begin
            total += log_size[slot];
            slot = (slot + 1) % DEPTH;
        end
        return total;
    endfunction

    // apply one command to the ring copy and return the response it earns
    function automatic rsp_t ring_lookup(input req_t item);
        rsp_t        result;
        int unsigned count;
        int unsigned slot;
        int unsigned acc;
        result = '0;
        if (item.cmd == CMD_ADD)
        begin
            log_handle[wr_slot] = item.entry_handle;
            log_size[wr_slot]   = item.entry_size;
            wr_slot = (wr_slot + 1) % DEPTH;
            // a full ring loses its oldest entry
            if (log_full)
                rd_slot = wr_slot;
            if (wr_slot == rd_slot)
                log_full = 1'b1;
        end
        else
        begin
            count = stored_entries();
            slot  = rd_slot;
            acc   = 0;
            // walk oldest to newest; zero-size entries can never match
            for (int k = 0; k < count; k++)
            begin
                if (item.char_pos < acc + log_size[slot])
                begin
                    result.found         = 1'b1;
                    result.found_handle  = log_handle[slot];
                    result.byte_in_entry = 16'(item.char_pos - acc);
                    break;
                end
                acc += log_size[slot];
                slot = (slot + 1) % DEPTH;
            end
        end
        return result;
    endfunction

    // ------------------------------------------------------------------------
    // request driver: valid is only lowered for a real gap, so it is never
    // dropped and raised again within one time step
    // ------------------------------------------------------------------------
    task automatic send_command(input req_t item);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            req       <= req_t'({$urandom, $urandom, $urandom});
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        // transaction taken at this edge: update the model in order
        lookup_results_q.push_back(ring_lookup(item));
        if (item.cmd == CMD_ADD)
            adds_sent++;
        else
            finds_sent++;
    endtask

    task automatic send_add(input logic [HDL_W-1:0] handle, input logic [SIZE_W-1:0] size);
        req_t item;
        item              = '0;
        item.cmd          = CMD_ADD;
        item.entry_handle = handle;
        item.entry_size   = size;
        item.char_pos     = OFF_W'($urandom);
        send_command(item);
    endtask

    task automatic send_find(input logic [OFF_W-1:0] offset);
        req_t item;
        item              = '0;
        item.cmd          = CMD_FIND;
        item.entry_handle = $urandom;
        item.entry_size   = SIZE_W'($urandom);
        item.char_pos     = offset;
        send_command(item);
    endtask

    // ------------------------------------------------------------------------
    // response side: random back-pressure and the checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            rsp_seen++;
            if (lookup_results_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("%0t: response with none awaited: found=%0b handle=%h byte=%h",
                             $realtime, rsp.found, rsp.found_handle, rsp.byte_in_entry);
            end
            else
            begin
                want = lookup_results_q.pop_front();
                if (want.found)
                    finds_hit++;
                if (rsp.found !== want.found || rsp.found_handle !== want.found_handle
                    || rsp.byte_in_entry !== want.byte_in_entry)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: mismatch: found %0b/%0b handle %h/%h byte %h/%h %s",
                                 $realtime, want.found, rsp.found, want.found_handle,
                                 rsp.found_handle, want.byte_in_entry, rsp.byte_in_entry,
                                 "(expected/actual)");
                end
            end
        end
    end

    // watchdog on cycles that move no transaction on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d responses owed",
                         quiet_cycles, lookup_results_q.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // straight after reset the ring is empty, so every find misses
    task automatic test_empty_ring();
        send_find('0);
        send_find('1);
    endtask

    // extremes of handle and size, a zero-size entry, and offsets on every
    // entry edge including exactly the total and the largest offset
    task automatic test_entry_edges();
        send_add('1, 16'd1);
        send_add('0, 16'd0);
        send_add(32'hA5A5_5A5A, 16'hFFFF);
        send_add(32'h0000_0001, 16'd3);
        send_find(20'd0);
        send_find(20'd1);
        send_find(20'd65536);
        send_find(20'd65539);
        send_find('1);
    endtask

    // more adds than slots, so the oldest entries are overwritten and the
    // write index wraps past the end of the ring
    task automatic test_ring_wrap();
        for (int k = 0; k <= DEPTH; k++)
            send_add($urandom, SIZE_W'($urandom_range(1, 9)));
        send_find(20'd0);
        send_find(OFF_W'(stored_chars() - 1));
    endtask

    task automatic test_random_traffic(input int unsigned items, input int unsigned idle_pct,
                                       input int unsigned stall_pct);
        int unsigned total;
        int unsigned pick;
        logic [SIZE_W-1:0] size;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < items; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                // mostly short entries so a find walks many of them
                pick = $urandom_range(99);
                if (pick < 65)
                    size = SIZE_W'($urandom_range(0, 40));
                else if (pick < 90)
                    size = SIZE_W'($urandom);
                else
                    size = (pick[0]) ? '1 : '0;
                send_add($urandom, size);
            end
            else
            begin
                total = stored_chars();
                pick  = $urandom_range(99);
                if (pick < 70 && total > 0)
                    send_find(OFF_W'($urandom_range(total - 1)));
                else if (pick < 80)
                    send_find(OFF_W'(total + $urandom_range(1)));
                else
                    send_find(OFF_W'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_ring();
        test_entry_edges();
        test_ring_wrap();

        test_random_traffic(RANDOM_ITEMS / 3, 37, 72);
        test_random_traffic(RANDOM_ITEMS / 3, 72, 37);
        test_random_traffic(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 0, 0);

        // all commands sent; let the owed responses drain
        req_valid <= 1'b0;
        while (lookup_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (lookup_results_q.size() != 0)
            mismatch_count++;

        $display("covered %0d adds and %0d finds (%0d located), %0d responses checked",
                 adds_sent, finds_sent, finds_hit, rsp_seen);
        $display("with wrap-around, zero-size entries and sender/receiver stalls; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ ring_log_offset_lookup_core.f @@
+incdir+design
design/rlol_pkg.sv
design/rlol_store.sv
design/rlol_seq.sv
design/ring_log_offset_lookup_core.sv
tb/testbench.sv
